FILE: rtl/core/plist_pkg.sv
package plist_pkg;

    localparam int OPCODE_W = 4;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADDFIRST = 4'd0,
        OP_ADDLAST  = 4'd1,
        OP_ADDAT    = 4'd2,
        OP_RMFIRST  = 4'd3,
        OP_RMLAST   = 4'd4,
        OP_RMAT     = 4'd5,
        OP_GETFIRST = 4'd6,
        OP_GETLAST  = 4'd7,
        OP_GETAT    = 4'd8,
        OP_SIZE     = 4'd9,
        OP_DISPLAY  = 4'd10
    } opcode_t;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

    typedef enum logic [1:0] {
        CA_HOLD,
        CA_INSERT,
        CA_REMOVE,
        CA_ROTATE
    } cell_action_t;

    typedef struct packed {
        cell_action_t        action;
        logic [IDX_W-1:0]    pos;
        logic [IDX_W-1:0]    last;
        logic [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]    rd_pos;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/plist_cmd_if.sv
interface plist_cmd_if
    import plist_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

FILE: rtl/core/plist_rsp_if.sv
interface plist_rsp_if
    import plist_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  data_out;
    logic [COUNT_W-1:0]         count_out;
    logic                       last_item;

    modport source (output valid, output status, output data_out, output count_out,
                    output last_item, input ready);
    modport sink   (input valid, input status, input data_out, input count_out,
                    input last_item, output ready);
endinterface

FILE: rtl/core/positional_list_engine_core.sv
// Channel | Dir | Fields                                    | Transfer
// cmd     | in  | opcode[3:0] position[4:0] value[31:0]     | valid && ready
// rsp     | out | status[1:0] data_out[31:0] count_out[4:0] | valid && ready
//         |     | last_item                                 |
// Any command but a display of a non-empty list yields one result, registered in the
// cycle after it is taken. Display on N > 0 entries leaves rsp idle, then yields N
// results, one per cycle unless rsp stalls, by rotating the cell chain once.
// cmd.ready is low during a display stream and while rsp holds an untaken result.
// rst_n clears the count and the result register; cell contents are undefined.
module positional_list_engine_core
    import plist_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    plist_cmd_if.sink      cmd,
    plist_rsp_if.source    rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic {
        S_CMD,
        S_DISP
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          disp_cnt_reg, disp_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [VALUE_W-1:0]     data_reg, data_next;
    logic                   last_reg, last_next;

    cell_ctrl_t             ctrl;
    logic [VALUE_W-1:0]     cell_data [DEPTH];
    logic [VALUE_W-1:0]     rd_chain  [DEPTH+1];

    logic                   out_free;
    logic                   cmd_xfer;
    logic [IDX_W-1:0]       pos_x;
    logic [IDX_W-1:0]       cnt_x;
    logic [IDX_W-1:0]       cnt_m1_x;
    logic [IDX_W-1:0]       tgt;

    assign out_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_CMD) && out_free;
    assign cmd_xfer = cmd.valid && cmd.ready;
    assign pos_x    = IDX_W'(cmd.position);
    assign cnt_x    = IDX_W'(count_reg);
    assign cnt_m1_x = IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        disp_cnt_next  = disp_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        tgt            = pos_x;

        ctrl.action = CA_HOLD;
        ctrl.pos    = '0;
        ctrl.last   = cnt_m1_x;
        ctrl.value  = cmd.value;
        ctrl.rd_pos = '0;

        case (opcode_t'(cmd.opcode))
            OP_ADDFIRST, OP_RMFIRST, OP_GETFIRST: tgt = '0;
            OP_ADDLAST:                           tgt = cnt_x;
            OP_RMLAST, OP_GETLAST:                tgt = cnt_m1_x;
            default:                              tgt = pos_x;
        endcase
        ctrl.pos    = tgt;
        ctrl.rd_pos = tgt;

        if (state_reg == S_DISP)
        begin
            if (out_free)
            begin
                ctrl.action    = CA_ROTATE;
                out_valid_next = 1'b1;
                status_next    = STAT_OK;
                data_next      = cell_data[0];
                last_next      = (disp_cnt_reg == count_reg - 1'b1);
                disp_cnt_next  = disp_cnt_reg + 1'b1;
                if (disp_cnt_reg == count_reg - 1'b1)
                    state_next = S_CMD;
            end
        end
        else if (cmd_xfer)
        begin
            out_valid_next = 1'b1;
            status_next    = STAT_OK;
            data_next      = '0;
            last_next      = 1'b1;
            case (opcode_t'(cmd.opcode))
                OP_ADDFIRST, OP_ADDLAST, OP_ADDAT:
                begin
                    if (tgt > cnt_x)
                        status_next = STAT_BADPOS;
                    else if (count_reg == DEPTH_C)
                        status_next = STAT_FULL;
                    else
                    begin
                        ctrl.action = CA_INSERT;
                        count_next  = count_reg + 1'b1;
                    end
                end
                OP_RMFIRST, OP_RMLAST, OP_RMAT:
                begin
                    if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else if (tgt >= cnt_x)
                        status_next = STAT_BADPOS;
                    else
                    begin
                        ctrl.action = CA_REMOVE;
                        count_next  = count_reg - 1'b1;
                    end
                end
                OP_GETFIRST, OP_GETLAST, OP_GETAT:
                begin
                    if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else if (tgt >= cnt_x)
                        status_next = STAT_BADPOS;
                    else
                        data_next = rd_chain[DEPTH];
                end
                OP_DISPLAY:
                begin
                    if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_DISP;
                        disp_cnt_next  = '0;
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CMD;
            count_reg     <= '0;
            disp_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
            data_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            disp_cnt_reg  <= disp_cnt_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            data_reg      <= data_next;
            last_reg      <= last_next;
        end
    end

    assign rd_chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_d;
        logic [VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_final
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        plist_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .rd_in      (rd_chain[i]),
            .data       (cell_data[i]),
            .rd_out     (rd_chain[i+1])
        );
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.data_out  = data_reg;
    assign rsp.count_out = COUNT_W'(count_reg);
    assign rsp.last_item = last_reg;

endmodule

FILE: rtl/core/plist_cell.sv
module plist_cell
    import plist_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0]  left_data,
    input  logic [VALUE_W-1:0]  right_data,
    input  logic [VALUE_W-1:0]  head_data,
    input  logic [VALUE_W-1:0]  rd_in,
    output logic [VALUE_W-1:0]  data,
    output logic [VALUE_W-1:0]  rd_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.action)
            CA_INSERT:
            begin
                if (MY_IDX == ctrl.pos)
                    data_next = ctrl.value;
                else if (MY_IDX > ctrl.pos)
                    data_next = left_data;
            end
            CA_REMOVE:
            begin
                if (MY_IDX >= ctrl.pos)
                    data_next = right_data;
            end
            CA_ROTATE:
            begin
                if (MY_IDX == ctrl.last)
                    data_next = head_data;
                else if (MY_IDX < ctrl.last)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign rd_out = rd_in | ((MY_IDX == ctrl.rd_pos) ? data_reg : '0);

endmodule

FILE: tb/positional_list_engine_core_tb.sv
module positional_list_engine_core_tb
    import plist_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int EPOCH_LEN    = 25;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd11;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;

    typedef enum int {
        MIX_GROW,
        MIX_BALANCED,
        MIX_SHRINK
    } traffic_mix_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } list_rsp_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [COUNT_W-1:0]  count;
    } dir_row_t;

    localparam list_rsp_t NO_RSP = '0;

    localparam dir_row_t DIRECTED [25] = '{
        '{OP_SIZE,     5'd0,  32'd0,        1'b1, STAT_OK,     32'd0,        5'd0},
        '{OP_RMFIRST,  5'd0,  32'd0,        1'b1, STAT_EMPTY,  32'd0,        5'd0},
        '{OP_RMLAST,   5'd0,  32'd0,        1'b1, STAT_EMPTY,  32'd0,        5'd0},
        '{OP_RMAT,     5'd0,  32'd0,        1'b1, STAT_EMPTY,  32'd0,        5'd0},
        '{OP_GETFIRST, 5'd0,  32'd0,        1'b1, STAT_EMPTY,  32'd0,        5'd0},
        '{OP_GETLAST,  5'd0,  32'd0,        1'b1, STAT_EMPTY,  32'd0,        5'd0},
        '{OP_GETAT,    5'd16, 32'd0,        1'b1, STAT_EMPTY,  32'd0,        5'd0},
        '{OP_DISPLAY,  5'd0,  32'd0,        1'b1, STAT_EMPTY,  32'd0,        5'd0},
        '{OP_ADDAT,    5'd1,  32'd5,        1'b1, STAT_BADPOS, 32'd0,        5'd0},
        '{OP_ADDFIRST, 5'd0,  32'h7fffffff, 1'b1, STAT_OK,     32'd0,        5'd1},
        '{OP_ADDLAST,  5'd0,  32'h80000000, 1'b1, STAT_OK,     32'd0,        5'd2},
        '{OP_ADDAT,    5'd1,  32'hffffffff, 1'b1, STAT_OK,     32'd0,        5'd3},
        '{OP_ADDAT,    5'd3,  32'd0,        1'b1, STAT_OK,     32'd0,        5'd4},
        '{OP_GETAT,    5'd16, 32'd0,        1'b1, STAT_BADPOS, 32'd0,        5'd4},
        '{OP_RMAT,     5'd4,  32'd0,        1'b1, STAT_BADPOS, 32'd0,        5'd4},
        '{OP_GETFIRST, 5'd0,  32'd0,        1'b1, STAT_OK,     32'h7fffffff, 5'd4},
        '{OP_GETLAST,  5'd0,  32'd0,        1'b1, STAT_OK,     32'd0,        5'd4},
        '{OP_GETAT,    5'd2,  32'd0,        1'b0, STAT_OK,     32'd0,        5'd0},
        '{OP_DISPLAY,  5'd0,  32'd0,        1'b0, STAT_OK,     32'd0,        5'd0},
        '{OP_SPARE_LO, 5'd0,  32'd0,        1'b1, STAT_OK,     32'd0,        5'd4},
        '{OP_SPARE_HI, 5'd16, 32'hffffffff, 1'b1, STAT_OK,     32'd0,        5'd4},
        '{OP_RMAT,     5'd1,  32'd0,        1'b0, STAT_OK,     32'd0,        5'd0},
        '{OP_RMLAST,   5'd0,  32'd0,        1'b0, STAT_OK,     32'd0,        5'd0},
        '{OP_RMFIRST,  5'd0,  32'd0,        1'b0, STAT_OK,     32'd0,        5'd0},
        '{OP_RMFIRST,  5'd0,  32'd0,        1'b1, STAT_OK,     32'd0,        5'd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plist_cmd_if cmd_ch ();
    plist_rsp_if rsp_ch ();

    positional_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
    int                        list_len;
    list_rsp_t                 pending_results [$];
    list_rsp_t                 step_results [$];
    int                        error_count = 0;
    bit                        no_stall = 1'b0;

    task automatic report_mismatch(string what);
        error_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic logic [STATUS_W-1:0] list_insert(int at, logic signed [VALUE_W-1:0] v);
        if (at > list_len)
            return STAT_BADPOS;
        if (list_len >= LIST_DEPTH)
            return STAT_FULL;
        for (int i = list_len; i > at; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[at] = v;
        list_len++;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] list_remove(int at);
        if (list_len == 0)
            return STAT_EMPTY;
        if (at >= list_len)
            return STAT_BADPOS;
        for (int i = at; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i+1];
        list_len--;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] list_read(int at, output logic [VALUE_W-1:0] rd);
        rd = '0;
        if (list_len == 0)
            return STAT_EMPTY;
        if (at >= list_len)
            return STAT_BADPOS;
        rd = list_mem[at];
        return STAT_OK;
    endfunction

    function automatic void apply_list_command(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                               logic signed [VALUE_W-1:0] val);
        logic [STATUS_W-1:0] st;
        logic [VALUE_W-1:0]  rd;
        st = STAT_OK;
        rd = '0;
        step_results.delete();
        case (op)
            OP_ADDFIRST: st = list_insert(0, val);
            OP_ADDLAST:  st = list_insert(list_len, val);
            OP_ADDAT:    st = list_insert(int'(pos), val);
            OP_RMFIRST:  st = list_remove(0);
            OP_RMLAST:   st = (list_len == 0) ? STAT_EMPTY : list_remove(list_len - 1);
            OP_RMAT:     st = list_remove(int'(pos));
            OP_GETFIRST: st = list_read(0, rd);
            OP_GETLAST:  st = (list_len == 0) ? STAT_EMPTY : list_read(list_len - 1, rd);
            OP_GETAT:    st = list_read(int'(pos), rd);
            OP_DISPLAY:
            begin
                if (list_len == 0)
                    st = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < list_len; i++)
                        step_results.push_back(list_rsp_t'{STAT_OK, list_mem[i],
                                                           COUNT_W'(list_len),
                                                           (i == list_len - 1)});
                    return;
                end
            end
            default: ;
        endcase
        step_results.push_back(list_rsp_t'{st, rd, COUNT_W'(list_len), 1'b1});
    endfunction

    task automatic send_command(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] val, bit use_typed, list_rsp_t typed_rsp);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.opcode   <= op;
        cmd_ch.position <= pos;
        cmd_ch.value    <= val;
        do
            @(negedge clk);
        while (!cmd_ch.ready);
        @(posedge clk);
        apply_list_command(op, pos, val);
        if (use_typed)
            pending_results.push_back(typed_rsp);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    task automatic wait_list_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        list_rsp_t           typed_rsp;
        traffic_mix_t        mix;
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  val;
        int                  r;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.opcode   <= '0;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        list_len = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k])
        begin
            typed_rsp = '{DIRECTED[k].status, DIRECTED[k].data, DIRECTED[k].count, 1'b1};
            send_command(DIRECTED[k].opcode, DIRECTED[k].position, DIRECTED[k].value,
                         DIRECTED[k].typed, typed_rsp);
        end
        wait_list_idle();

        // fill to capacity, then hit the full list from the add-first and add-at paths
        while (list_len < LIST_DEPTH)
            send_command(OP_ADDLAST, POS_W'($urandom_range(0, LIST_DEPTH)), $urandom,
                         1'b0, NO_RSP);
        send_command(OP_ADDFIRST, '0, 32'h12345678, 1'b1,
                     list_rsp_t'{STAT_FULL, 32'd0, 5'd16, 1'b1});
        send_command(OP_ADDAT, 5'd16, 32'hdeadbeef, 1'b1,
                     list_rsp_t'{STAT_FULL, 32'd0, 5'd16, 1'b1});
        send_command(OP_DISPLAY, '0, '0, 1'b0, NO_RSP);
        wait_list_idle();

        for (int e = 0; e < RANDOM_ITEMS / EPOCH_LEN; e++)
        begin
            mix = traffic_mix_t'(e % 3);
            no_stall = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < EPOCH_LEN; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                else if (mix == MIX_GROW && r < 64)
                    op = OPCODE_W'($urandom_range(OP_ADDFIRST, OP_ADDAT));
                else if (mix == MIX_SHRINK && r < 64)
                    op = OPCODE_W'($urandom_range(OP_RMFIRST, OP_RMAT));
                else
                    op = OPCODE_W'($urandom_range(OP_ADDFIRST, OP_DISPLAY));
                if ($urandom_range(0, 3) != 0)
                    pos = POS_W'($urandom_range(0, list_len));
                else
                    pos = POS_W'($urandom_range(0, LIST_DEPTH));
                if ($urandom_range(0, 7) == 0)
                    val = 32'h7fffffff ^ {VALUE_W{$urandom_range(0, 1) == 1}};
                else
                    val = $urandom;
                send_command(op, pos, val, 1'b0, NO_RSP);
            end
            // hold the sender until every result of this epoch has drained
            wait_list_idle();
        end

        no_stall = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[positional_list_engine_core] OK");
        else
            $display("[positional_list_engine_core] ERROR");
        $finish;
    end

    initial
    begin : rsp_sink
        int        stall;
        list_rsp_t got;
        list_rsp_t want;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_stall ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(negedge clk);
            while (!rsp_ch.valid);
            got = '{rsp_ch.status, rsp_ch.data_out, rsp_ch.count_out, rsp_ch.last_item};
            @(posedge clk);
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected transfer st=%0d data=%h cnt=%0d last=%0b",
                                          got.status, got.data, got.count, got.last));
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        {"got st=%0d data=%h cnt=%0d last=%0b, ",
                         "want st=%0d data=%h cnt=%0d last=%0b"},
                        got.status, got.data, got.count, got.last,
                        want.status, want.data, want.count, want.last));
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("[positional_list_engine_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/plist_pkg.sv
rtl/core/plist_cmd_if.sv
rtl/core/plist_rsp_if.sv
rtl/core/plist_cell.sv
rtl/core/positional_list_engine_core.sv
tb/positional_list_engine_core_tb.sv
